// File: design/cbd_pkg.sv
// Shared types and constants for the clipped blit descriptor block.
package cbd_pkg;

    localparam int FieldW  = 16;
    localparam int CoordW  = 20;
    localparam int RegW    = 14;
    localparam int DimW    = 13;
    localparam int BufW    = 3;
    localparam int OffW    = 26;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] REG_SRC_ROW_BYTES = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SRC_WIDTH     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SRC_HEIGHT    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_DST_WIDTH     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_DST_HEIGHT    = 3'd4;

    typedef logic signed [CoordW-1:0] coord_t;

    // One axis of a request: source start, destination start and length.
    typedef struct packed {
        coord_t s;
        coord_t d;
        coord_t n;
    } axis_t;

    typedef struct packed {
        logic [BufW-1:0] src;
        logic [BufW-1:0] dst;
    } bufs_t;

    typedef struct packed {
        axis_t x;
        axis_t y;
        bufs_t bufs;
    } req_t;

    typedef struct packed {
        logic [DimW-1:0] src_width;
        logic [DimW-1:0] src_height;
        logic [DimW-1:0] dst_width;
        logic [DimW-1:0] dst_height;
    } screen_t;

    typedef struct packed {
        logic            empty;
        logic            top_down;
        logic [DimW-1:0] width;
        logic [DimW-1:0] height;
        logic [DimW-1:0] src_col;
        logic [DimW-1:0] dst_col;
        logic [DimW-1:0] src_row;
        logic [DimW-1:0] dst_row;
        bufs_t           bufs;
    } clip_t;

endpackage

// File: design/cbd_clip.sv
// Three-stage clipping pipeline: leading edges, trailing edges, copy order.
module cbd_clip import cbd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  req_t    in_req,
    input  screen_t screen,
    output logic    out_valid,
    input  logic    out_ready,
    output clip_t   out_clip
);

    logic  v1_reg, v2_reg, v3_reg;
    logic  en1, en2, en3;
    axis_t x1_reg, y1_reg, x2_reg, y2_reg;
    axis_t x1_next, y1_next, x2_next, y2_next;
    bufs_t b1_reg, b2_reg;
    clip_t c3_reg, c3_next;

    // Negative source start first, then negative destination start.
    function automatic axis_t clip_lead(axis_t a);
        axis_t r;
        r = a;
        if (r.s[CoordW-1]) begin
            r.d = r.d - r.s;
            r.n = r.n + r.s;
            r.s = '0;
        end
        if (r.d[CoordW-1]) begin
            r.s = r.s - r.d;
            r.n = r.n + r.d;
            r.d = '0;
        end
        return r;
    endfunction

    // Source trailing edge first, then destination trailing edge.
    function automatic axis_t clip_trail(axis_t a, logic [DimW-1:0] lim_s,
                                         logic [DimW-1:0] lim_d);
        axis_t  r;
        coord_t ls;
        coord_t ld;
        r  = a;
        ls = coord_t'({{(CoordW-DimW){1'b0}}, lim_s});
        ld = coord_t'({{(CoordW-DimW){1'b0}}, lim_d});
        if (r.s + r.n > ls) begin
            r.n = ls - r.s;
        end
        if (r.d + r.n > ld) begin
            r.n = ld - r.d;
        end
        return r;
    endfunction

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign x1_next = clip_lead(in_req.x);
    assign y1_next = clip_lead(in_req.y);
    assign x2_next = clip_trail(x1_reg, screen.src_width, screen.dst_width);
    assign y2_next = clip_trail(y1_reg, screen.src_height, screen.dst_height);

    always_comb begin
        logic   td;
        coord_t s_last;
        coord_t d_last;
        td     = y2_reg.d < y2_reg.s;
        s_last = y2_reg.s + y2_reg.n - coord_t'(1);
        d_last = y2_reg.d + y2_reg.n - coord_t'(1);
        c3_next.empty    = x2_reg.n[CoordW-1] || (x2_reg.n == '0) ||
                           y2_reg.n[CoordW-1] || (y2_reg.n == '0);
        c3_next.top_down = td;
        c3_next.width    = x2_reg.n[DimW-1:0];
        c3_next.height   = y2_reg.n[DimW-1:0];
        c3_next.src_col  = x2_reg.s[DimW-1:0];
        c3_next.dst_col  = x2_reg.d[DimW-1:0];
        c3_next.src_row  = td ? y2_reg.s[DimW-1:0] : s_last[DimW-1:0];
        c3_next.dst_row  = td ? y2_reg.d[DimW-1:0] : d_last[DimW-1:0];
        c3_next.bufs     = b2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            b1_reg <= in_req.bufs;
        end
        if (en2 && v1_reg) begin
            x2_reg <= x2_next;
            y2_reg <= y2_next;
            b2_reg <= b1_reg;
        end
        if (en3 && v2_reg) begin
            c3_reg <= c3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_clip  = c3_reg;

endmodule

// File: design/clipped_blit_descriptor.sv
// Clipped blit descriptor: clips a blit request to both screens and gives offsets.
//
// Each beat on the s_ channel is one blit request; each beat on the m_ channel
// is its descriptor: clipped size, copy direction and the byte offsets of the
// first row in copy order, or an empty flag with zeroed numbers.
// The user must write the five screen registers through cfg_we/cfg_index/cfg_wdata,
// one per cycle, only while no request is in flight; the block does not check this.
// The datapath is six registered stages: input, leading-edge clip,
// trailing-edge clip, copy order, row-stride multiply and offset add.
// A taken request reaches m_tvalid through the stage registers in the order above, and
// one request is accepted every cycle while the output side keeps up.
// Every stage moves forward whenever the stage after it is empty or moving,
// so bubbles are squeezed out. When the receiver holds m_tready low the
// output beat stays put and the pipe keeps filling; s_tready falls only
// once all six stages hold a request.
// Reset (aresetn low at a clock edge) empties the pipe and returns the
// screen registers to 320 bytes per row, 320 by 200 pixels on both screens.
module clipped_blit_descriptor import cbd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration write port.
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [RegW-1:0]    cfg_wdata,
    // Requests. tdata from bit 0 up: from_x, from_y, req_width, req_height,
    // to_x, to_y, src_buffer, dst_buffer, zero pad.
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [103:0]       s_tdata,
    // Descriptors. tdata from bit 0 up: top_down, clip_width, clip_height,
    // out_src_buffer, out_dst_buffer, src_first_offset, dst_first_offset, zero pad.
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [87:0]        m_tdata,
    // tuser: nothing_to_copy.
    output logic               m_tuser
);

    logic [RegW-1:0] src_row_bytes_reg;
    logic [DimW-1:0] src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    screen_t         screen;

    logic  v0_reg, en0;
    req_t  req_reg, req_next;
    logic  clip_ready, clip_valid;
    clip_t clip;

    logic                 v4_reg, en4, en5;
    logic [OffW-1:0]      src_prod_reg, dst_prod_reg;
    logic [RegW+DimW-1:0] src_prod_full;
    logic [2*DimW-1:0]    dst_prod_full;
    clip_t                c4_reg;

    logic            m_tvalid_reg;
    logic            empty_reg, top_down_reg;
    logic [DimW-1:0] width_reg, height_reg;
    bufs_t           bufs_reg;
    logic [OffW-1:0] src_off_reg, dst_off_reg;
    logic [OffW-1:0] src_off_next, dst_off_next;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_row_bytes_reg <= RegW'(320);
            src_width_reg     <= DimW'(320);
            src_height_reg    <= DimW'(200);
            dst_width_reg     <= DimW'(320);
            dst_height_reg    <= DimW'(200);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SRC_ROW_BYTES: src_row_bytes_reg <= cfg_wdata;
                REG_SRC_WIDTH:     src_width_reg     <= cfg_wdata[DimW-1:0];
                REG_SRC_HEIGHT:    src_height_reg    <= cfg_wdata[DimW-1:0];
                REG_DST_WIDTH:     dst_width_reg     <= cfg_wdata[DimW-1:0];
                REG_DST_HEIGHT:    dst_height_reg    <= cfg_wdata[DimW-1:0];
                default: ;
            endcase
        end
    end

    assign screen.src_width  = src_width_reg;
    assign screen.src_height = src_height_reg;
    assign screen.dst_width  = dst_width_reg;
    assign screen.dst_height = dst_height_reg;

    // Stage handshakes, from the output back to the input.
    assign en5      = !m_tvalid_reg || m_tready;
    assign en4      = !v4_reg || en5;
    assign en0      = !v0_reg || clip_ready;
    assign s_tready = en0;

    // Coordinates are widened so that the clip arithmetic never wraps.
    assign req_next.x.s     = CoordW'(signed'(s_tdata[15:0]));
    assign req_next.y.s     = CoordW'(signed'(s_tdata[31:16]));
    assign req_next.x.n     = CoordW'(signed'(s_tdata[47:32]));
    assign req_next.y.n     = CoordW'(signed'(s_tdata[63:48]));
    assign req_next.x.d     = CoordW'(signed'(s_tdata[79:64]));
    assign req_next.y.d     = CoordW'(signed'(s_tdata[95:80]));
    assign req_next.bufs.src = s_tdata[98:96];
    assign req_next.bufs.dst = s_tdata[101:99];

    always_ff @(posedge aclk) begin
        if (en0 && s_tvalid) begin
            req_reg <= req_next;
        end
    end

    cbd_clip u_clip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v0_reg),
        .in_ready  (clip_ready),
        .in_req    (req_reg),
        .screen    (screen),
        .out_valid (clip_valid),
        .out_ready (en4),
        .out_clip  (clip)
    );

    // Row stride multiplies; offsets wrap at 26 bits.
    assign src_prod_full = src_row_bytes_reg * clip.src_row;
    assign dst_prod_full = dst_width_reg * clip.dst_row;

    always_ff @(posedge aclk) begin
        if (en4 && clip_valid) begin
            src_prod_reg <= src_prod_full[OffW-1:0];
            dst_prod_reg <= dst_prod_full[OffW-1:0];
            c4_reg       <= clip;
        end
    end

    assign src_off_next = src_prod_reg + OffW'(c4_reg.src_col);
    assign dst_off_next = dst_prod_reg + OffW'(c4_reg.dst_col);

    // An empty request reports zeros everywhere in tdata but the buffer indices.
    always_ff @(posedge aclk) begin
        if (en5 && v4_reg) begin
            empty_reg    <= c4_reg.empty;
            top_down_reg <= !c4_reg.empty && c4_reg.top_down;
            width_reg    <= c4_reg.empty ? '0 : c4_reg.width;
            height_reg   <= c4_reg.empty ? '0 : c4_reg.height;
            bufs_reg     <= c4_reg.bufs;
            src_off_reg  <= c4_reg.empty ? '0 : src_off_next;
            dst_off_reg  <= c4_reg.empty ? '0 : dst_off_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (en0) v0_reg <= s_tvalid;
            if (en4) v4_reg <= clip_valid;
            if (en5) m_tvalid_reg <= v4_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = empty_reg;
    assign m_tdata  = {3'b000, dst_off_reg, src_off_reg, bufs_reg.dst, bufs_reg.src,
                       height_reg, width_reg, top_down_reg};

`ifndef SYNTHESIS
    // A copy that is not empty has a real size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (width_reg != '0) && (height_reg != '0))
        else $error("non-empty descriptor with zero size");

    // The clipped width fits on both screens.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (width_reg <= src_width_reg) &&
                                 (width_reg <= dst_width_reg))
        else $error("clipped width exceeds a screen");

    // The clipped height fits on both screens.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (height_reg <= src_height_reg) &&
                                 (height_reg <= dst_height_reg))
        else $error("clipped height exceeds a screen");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the clipped blit descriptor: directed and random requests.
module tb_top import cbd_pkg::*; ();

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic signed [FieldW-1:0] from_x;
        logic signed [FieldW-1:0] from_y;
        logic signed [FieldW-1:0] req_width;
        logic signed [FieldW-1:0] req_height;
        logic signed [FieldW-1:0] to_x;
        logic signed [FieldW-1:0] to_y;
        logic [BufW-1:0]          src_buffer;
        logic [BufW-1:0]          dst_buffer;
    } blit_req_t;

    typedef struct packed {
        logic            nothing_to_copy;
        logic            top_down;
        logic [DimW-1:0] clip_width;
        logic [DimW-1:0] clip_height;
        logic [BufW-1:0] out_src_buffer;
        logic [BufW-1:0] out_dst_buffer;
        logic [OffW-1:0] src_first_offset;
        logic [OffW-1:0] dst_first_offset;
    } blit_desc_t;

    typedef struct packed {
        blit_req_t  req;
        logic       typed;
        blit_desc_t desc;
    } directed_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [RegW-1:0]    cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [103:0]       s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [87:0]        m_tdata;
    logic               m_tuser;

    // Screen registers as the block should hold them.
    logic [RegW-1:0] scr_row_bytes;
    logic [DimW-1:0] scr_src_w;
    logic [DimW-1:0] scr_src_h;
    logic [DimW-1:0] scr_dst_w;
    logic [DimW-1:0] scr_dst_h;

    blit_desc_t    pending_desc[$];
    directed_row_t directed_rows[$];
    int            src_idle_pct;
    int            sink_idle_pct;
    int            error_count;
    int            cycle_count;

    clipped_blit_descriptor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Clips one request against both screens and works out the first-row offsets.
    function automatic blit_desc_t clip_blit(blit_req_t r);
        longint fx, fy, w, h, tx, ty;
        longint sw, sh, dw, dh, srow, drow, soff, doff;
        logic td;
        blit_desc_t d;
        fx = r.from_x;
        fy = r.from_y;
        w  = r.req_width;
        h  = r.req_height;
        tx = r.to_x;
        ty = r.to_y;
        sw = scr_src_w;
        sh = scr_src_h;
        dw = scr_dst_w;
        dh = scr_dst_h;
        if (fx < 0) begin tx -= fx; w += fx; fx = 0; end
        if (fy < 0) begin ty -= fy; h += fy; fy = 0; end
        if (tx < 0) begin fx -= tx; w += tx; tx = 0; end
        if (ty < 0) begin fy -= ty; h += ty; ty = 0; end
        if (fx + w > sw) w = sw - fx;
        if (tx + w > dw) w = dw - tx;
        if (fy + h > sh) h = sh - fy;
        if (ty + h > dh) h = dh - ty;
        d = '0;
        d.out_src_buffer = r.src_buffer;
        d.out_dst_buffer = r.dst_buffer;
        if (w <= 0 || h <= 0) begin
            d.nothing_to_copy = 1'b1;
            return d;
        end
        td = (ty < fy);
        // Bottom-up copies start from the last row of the clipped rectangle.
        srow = td ? fy : fy + h - 1;
        drow = td ? ty : ty + h - 1;
        soff = longint'(scr_row_bytes) * srow + fx;
        doff = dw * drow + tx;
        d.top_down         = td;
        d.clip_width       = w[DimW-1:0];
        d.clip_height      = h[DimW-1:0];
        d.src_first_offset = soff[OffW-1:0];
        d.dst_first_offset = doff[OffW-1:0];
        return d;
    endfunction

    function automatic blit_req_t mk_req(int fx, int fy, int w, int h, int tx, int ty,
                                         int sb, int db);
        blit_req_t r;
        r.from_x     = fx[FieldW-1:0];
        r.from_y     = fy[FieldW-1:0];
        r.req_width  = w[FieldW-1:0];
        r.req_height = h[FieldW-1:0];
        r.to_x       = tx[FieldW-1:0];
        r.to_y       = ty[FieldW-1:0];
        r.src_buffer = sb[BufW-1:0];
        r.dst_buffer = db[BufW-1:0];
        return r;
    endfunction

    function automatic blit_desc_t mk_desc(bit empty, bit td, int w, int h, int sb, int db,
                                           int sof, int dof);
        blit_desc_t d;
        d.nothing_to_copy  = empty;
        d.top_down         = td;
        d.clip_width       = w[DimW-1:0];
        d.clip_height      = h[DimW-1:0];
        d.out_src_buffer   = sb[BufW-1:0];
        d.out_dst_buffer   = db[BufW-1:0];
        d.src_first_offset = sof[OffW-1:0];
        d.dst_first_offset = dof[OffW-1:0];
        return d;
    endfunction

    function automatic int near_span(int span);
        return int'($urandom_range(span + span / 2 + 8)) - span / 4 - 4;
    endfunction

    // Mostly requests around the screens, some with fully random fields.
    function automatic blit_req_t rand_req();
        blit_req_t r;
        if ($urandom_range(99) < 25) begin
            r.from_x     = FieldW'($urandom);
            r.from_y     = FieldW'($urandom);
            r.req_width  = FieldW'($urandom);
            r.req_height = FieldW'($urandom);
            r.to_x       = FieldW'($urandom);
            r.to_y       = FieldW'($urandom);
        end else begin
            r = mk_req(near_span(int'(scr_src_w)), near_span(int'(scr_src_h)),
                       near_span(int'(scr_src_w)), near_span(int'(scr_src_h)),
                       near_span(int'(scr_dst_w)), near_span(int'(scr_dst_h)), 0, 0);
            // Same row on both sides is where the copy order flips.
            if ($urandom_range(9) == 0)
                r.to_y = r.from_y;
        end
        r.src_buffer = BufW'($urandom_range(7));
        r.dst_buffer = BufW'($urandom_range(7));
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_req(blit_req_t r, bit typed, blit_desc_t typed_desc);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, r.dst_buffer, r.src_buffer, r.to_y, r.to_x,
                     r.req_height, r.req_width, r.from_y, r.from_x};
        do @(posedge aclk); while (!s_tready);
        pending_desc.push_back(typed ? typed_desc : clip_blit(r));
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_SRC_ROW_BYTES: scr_row_bytes = val;
            REG_SRC_WIDTH:     scr_src_w = val[DimW-1:0];
            REG_SRC_HEIGHT:    scr_src_h = val[DimW-1:0];
            REG_DST_WIDTH:     scr_dst_w = val[DimW-1:0];
            REG_DST_HEIGHT:    scr_dst_h = val[DimW-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Waits for the pipe to drain, then rewrites every screen register.
    task automatic apply_screen(int rb, int sw, int sh, int dw, int dh);
        s_tvalid <= 1'b0;
        wait (pending_desc.size() == 0);
        @(negedge aclk);
        write_reg(REG_SRC_ROW_BYTES, rb[RegW-1:0]);
        write_reg(REG_SRC_WIDTH, sw[RegW-1:0]);
        write_reg(REG_SRC_HEIGHT, sh[RegW-1:0]);
        write_reg(REG_DST_WIDTH, dw[RegW-1:0]);
        write_reg(REG_DST_HEIGHT, dh[RegW-1:0]);
        // Indexes past the last register must leave the screens alone.
        for (int i = int'(REG_DST_HEIGHT) + 1; i < 2 ** CfgIdxW; i++)
            write_reg(i[CfgIdxW-1:0], RegW'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_req(rand_req(), 1'b0, '0);
    endtask

    function automatic void check_field(string name, longint exp_val, longint act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge aclk) begin
        blit_desc_t exp_desc;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_desc.size() == 0) begin
                $error("descriptor beat with no request outstanding");
                error_count++;
            end else begin
                exp_desc = pending_desc.pop_front();
                check_field("nothing_to_copy", exp_desc.nothing_to_copy, m_tuser);
                check_field("top_down", exp_desc.top_down, m_tdata[0]);
                check_field("clip_width", exp_desc.clip_width, m_tdata[13:1]);
                check_field("clip_height", exp_desc.clip_height, m_tdata[26:14]);
                check_field("out_src_buffer", exp_desc.out_src_buffer, m_tdata[29:27]);
                check_field("out_dst_buffer", exp_desc.out_dst_buffer, m_tdata[32:30]);
                check_field("src_first_offset", exp_desc.src_first_offset, m_tdata[58:33]);
                check_field("dst_first_offset", exp_desc.dst_first_offset, m_tdata[84:59]);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[clipped_blit_descriptor] ERROR");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        src_idle_pct  = 17;
        sink_idle_pct = 69;
        scr_row_bytes = 320;
        scr_src_w     = 320;
        scr_src_h     = 200;
        scr_dst_w     = 320;
        scr_dst_h     = 200;

        // Reset screens: 320 bytes per row, 320 by 200 on both sides.
        directed_rows.push_back({mk_req(0, 0, 320, 200, 0, 0, 1, 2), 1'b1,
                                 mk_desc(0, 0, 320, 200, 1, 2, 63680, 63680)});
        directed_rows.push_back({mk_req(10, 10, 0, 5, 20, 20, 3, 4), 1'b1,
                                 mk_desc(1, 0, 0, 0, 3, 4, 0, 0)});
        directed_rows.push_back({mk_req(10, 10, 5, 0, 20, 20, 5, 6), 1'b1,
                                 mk_desc(1, 0, 0, 0, 5, 6, 0, 0)});
        directed_rows.push_back({mk_req(0, 0, -1, 10, 0, 0, 7, 0), 1'b1,
                                 mk_desc(1, 0, 0, 0, 7, 0, 0, 0)});
        directed_rows.push_back({mk_req(0, 0, 10, -32768, 0, 0, 0, 7), 1'b1,
                                 mk_desc(1, 0, 0, 0, 0, 7, 0, 0)});
        directed_rows.push_back({mk_req(32767, 32767, 32767, 32767, 32767, 32767, 7, 7),
                                 1'b1, mk_desc(1, 0, 0, 0, 7, 7, 0, 0)});
        directed_rows.push_back({mk_req(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0),
                                 1'b1, mk_desc(1, 0, 0, 0, 0, 0, 0, 0)});
        directed_rows.push_back({mk_req(10, 50, 16, 8, 20, 10, 0, 1), 1'b1,
                                 mk_desc(0, 1, 16, 8, 0, 1, 16010, 3220)});
        directed_rows.push_back({mk_req(5, 30, 4, 4, 100, 30, 2, 3), 1'b1,
                                 mk_desc(0, 0, 4, 4, 2, 3, 10565, 10660)});
        directed_rows.push_back({mk_req(400, 0, 10, 10, 0, 0, 4, 5), 1'b1,
                                 mk_desc(1, 0, 0, 0, 4, 5, 0, 0)});
        directed_rows.push_back({mk_req(319, 199, 1, 1, 319, 199, 6, 1), 1'b1,
                                 mk_desc(0, 0, 1, 1, 6, 1, 63999, 63999)});
        directed_rows.push_back({mk_req(0, 1, 320, 199, 0, 0, 1, 1), 1'b1,
                                 mk_desc(0, 1, 320, 199, 1, 1, 320, 0)});
        directed_rows.push_back({mk_req(-5, -3, 20, 10, 40, 40, 2, 2), 1'b0, blit_desc_t'('0)});
        directed_rows.push_back({mk_req(30, 30, 20, 10, -7, -2, 3, 3), 1'b0, blit_desc_t'('0)});
        directed_rows.push_back({mk_req(310, 0, 50, 10, 0, 100, 4, 4), 1'b0, blit_desc_t'('0)});
        directed_rows.push_back({mk_req(0, 0, 50, 10, 300, 100, 5, 5), 1'b0, blit_desc_t'('0)});
        directed_rows.push_back({mk_req(0, 190, 10, 40, 0, 0, 6, 6), 1'b0, blit_desc_t'('0)});
        directed_rows.push_back({mk_req(0, 0, 10, 40, 0, 180, 7, 6), 1'b0, blit_desc_t'('0)});
        directed_rows.push_back({mk_req(-10, -10, 400, 300, -20, -20, 0, 3), 1'b0,
                                 blit_desc_t'('0)});
        directed_rows.push_back({mk_req(-32768, 5, 32767, 20, 100, 5, 1, 4), 1'b0,
                                 blit_desc_t'('0)});
        directed_rows.push_back({mk_req(20, -300, 30, 400, 50, 100, 2, 5), 1'b0,
                                 blit_desc_t'('0)});

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].desc);

        apply_screen($urandom_range(1, 8192), $urandom_range(1, 4096), $urandom_range(1, 4096),
                     $urandom_range(1, 4096), $urandom_range(1, 4096));
        run_random(170);
        apply_screen(16383, 8191, 8191, 8191, 8191);
        run_random(170);

        src_idle_pct  = 69;
        sink_idle_pct = 17;
        apply_screen(1, 1, 1, 1, 1);
        run_random(170);
        apply_screen(8192, 4096, 4096, 4096, 4096);
        run_random(170);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // A zero-sized screen clips everything to empty.
        apply_screen(0, 0, 0, 0, 0);
        run_random(60);
        apply_screen($urandom_range(16, 640), $urandom_range(16, 400), $urandom_range(16, 300),
                     $urandom_range(16, 400), $urandom_range(16, 300));
        run_random(260);

        s_tvalid <= 1'b0;
        wait (pending_desc.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("[clipped_blit_descriptor] OK");
        else
            $display("[clipped_blit_descriptor] ERROR");
        $finish;
    end

endmodule

// File: sim.f
design/cbd_pkg.sv
design/cbd_clip.sv
design/clipped_blit_descriptor.sv
tb/tb_top.sv
